// ===== src/wav_riff_pcm_parser_core_assert.svh =====
// Assertion macros for the WAV parser core checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef WAV_RIFF_PCM_PARSER_CORE_ASSERT_SVH
`define WAV_RIFF_PCM_PARSER_CORE_ASSERT_SVH
// same-cycle implication, off during reset
`define WRP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, off during reset
`define WRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
// next-cycle implication, always on
`define WRP_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/wrp_pkg.sv =====
// Shared types and constants of the WAV parser core.
// No dependencies.
package wrp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] sample_q31;
        logic [15:0]        channel_index;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate_hz;
        logic [5:0]         bits_per_sample;
        logic [30:0]        frame_total;
        logic [2:0]         error_code;
    } t_out;

    typedef enum logic [2:0] {
        PH_TOP, PH_HDR, PH_BODY, PH_PAD, PH_DIV, PH_DATA, PH_DONE, PH_HALT
    } t_phase;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [17:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [17:0] rem;
    } t_div_rsp;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_OK     = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_TAGS      = 3'd1;
    localparam logic [2:0] ERR_HDR_TRUNC = 3'd2;
    localparam logic [2:0] ERR_FORMAT    = 3'd3;
    localparam logic [2:0] ERR_WIDTH     = 3'd4;
    localparam logic [2:0] ERR_DAT_TRUNC = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int QDEPTH = 4;

endpackage

// ===== src/wrp_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit by 18-bit.
// Depends on wrp_pkg.
module wrp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrp_pkg::t_div_req i_req,
    output wrp_pkg::t_div_rsp o_rsp
);
    import wrp_pkg::*;

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [17:0] r_rem, r_dsr;
    logic [18:0] sh;
    logic        fits;

    assign sh   = {r_rem, r_quo[31]};
    assign fits = sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[30:0], fits};
                r_rem <= fits ? 18'(sh - {1'b0, r_dsr}) : sh[17:0];
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quo: r_quo, rem: r_rem};
endmodule

// ===== src/wrp_front.sv =====
// Front end: byte parser, chunk walker and sample assembler; pushes results.
// Depends on wrp_pkg and wrp_div.
module wrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wrp_pkg::t_in  i_data,
    output logic          o_stall,
    input  logic [2:0]    i_free,
    output logic          o_push,
    output wrp_pkg::t_out o_res
);
    import wrp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt, r_tag, n_tag, r_len, n_len;
    logic [15:0] r_fmt, n_fmt, r_ch, n_ch, r_width, n_width, r_chan, n_chan;
    logic [31:0] r_rate, n_rate, r_left, n_left, r_emit, n_emit, r_asm, n_asm;
    logic [1:0]  r_bis, n_bis;
    logic        r_eofp, n_eofp, r_pend_v, n_pend_v;
    t_out        r_pend, n_pend;

    t_div_req div_req;
    t_div_rsp div_rsp;

    wrp_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign o_stall = r_pend_v || (r_phase == PH_DIV) || (i_free < 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TOP;
            r_cnt    <= '0;
            r_tag    <= '0;
            r_len    <= '0;
            r_fmt    <= '0;
            r_ch     <= '0;
            r_rate   <= '0;
            r_width  <= '0;
            r_left   <= '0;
            r_emit   <= '0;
            r_asm    <= '0;
            r_bis    <= '0;
            r_chan   <= '0;
            r_eofp   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_fmt    <= n_fmt;
            r_ch     <= n_ch;
            r_rate   <= n_rate;
            r_width  <= n_width;
            r_left   <= n_left;
            r_emit   <= n_emit;
            r_asm    <= n_asm;
            r_bis    <= n_bis;
            r_chan   <= n_chan;
            r_eofp   <= n_eofp;
            r_pend_v <= n_pend_v;
        end
        r_pend <= n_pend;
    end

    always_comb begin
        logic        accept, r0v, r1v, fmt_ok, wid_ok;
        logic [7:0]  b;
        logic [2:0]  nb;
        logic [31:0] a32, smp;
        logic [16:0] chn;
        t_out        r0, r1, tmp;

        accept = i_valid && !o_stall;
        b      = i_data.in_byte;
        nb     = r_width[5:3];
        r0v = 1'b0; r1v = 1'b0; r0 = '0; r1 = '0; tmp = '0;
        a32 = '0; smp = '0; chn = '0;
        fmt_ok = 1'b0; wid_ok = 1'b0;

        n_phase = r_phase; n_cnt = r_cnt; n_tag = r_tag; n_len = r_len;
        n_fmt = r_fmt; n_ch = r_ch; n_rate = r_rate; n_width = r_width;
        n_left = r_left; n_emit = r_emit; n_asm = r_asm; n_bis = r_bis;
        n_chan = r_chan; n_eofp = r_eofp; n_pend_v = 1'b0; n_pend = r_pend;
        o_push = 1'b0; o_res = r_pend;
        div_req.start = 1'b0;

        if (r_pend_v) begin
            o_push = 1'b1;
            o_res  = r_pend;
        end else if (r_phase == PH_DIV) begin
            if (div_rsp.done) begin
                tmp = '0;
                tmp.kind            = KIND_FORMAT;
                tmp.channel_count   = r_ch;
                tmp.sample_rate_hz  = r_rate;
                tmp.bits_per_sample = r_width[5:0];
                tmp.frame_total     = div_rsp.quo[30:0];
                r0v = 1'b1; r0 = tmp;
                n_emit  = r_len - {14'd0, div_rsp.rem};
                n_left  = r_len;
                n_asm   = '0;
                n_bis   = '0;
                n_chan  = '0;
                n_phase = PH_DATA;
                if (r_eofp) begin
                    tmp = '0;
                    tmp.kind = KIND_ERROR;
                    tmp.error_code = ERR_DAT_TRUNC;
                    r1v = 1'b1; r1 = tmp;
                    n_phase = PH_TOP; n_cnt = '0; n_tag = '0; n_len = '0;
                    n_fmt = '0; n_ch = '0; n_rate = '0; n_width = '0;
                    n_left = '0; n_emit = '0; n_asm = '0; n_bis = '0;
                    n_chan = '0; n_eofp = 1'b0;
                end
            end
        end else if (accept) begin
            unique case (r_phase)
                PH_TOP: begin
                    n_tag = {b, r_tag[31:8]};
                    if ((r_cnt == 32'd3 && n_tag != TAG_RIFF) ||
                        (r_cnt == 32'd11 && n_tag != TAG_WAVE)) begin
                        tmp = '0; tmp.kind = KIND_ERROR; tmp.error_code = ERR_TAGS;
                        r0v = 1'b1; r0 = tmp;
                        n_phase = PH_HALT;
                    end else begin
                        n_cnt = r_cnt + 32'd1;
                        if (n_cnt >= 32'd12) begin
                            n_cnt   = '0;
                            n_phase = PH_HDR;
                        end
                    end
                end
                PH_HDR: begin
                    if (r_cnt < 32'd4) n_tag = {b, r_tag[31:8]};
                    else n_len = {b, r_len[31:8]};
                    n_cnt = r_cnt + 32'd1;
                    if (n_cnt >= 32'd8) begin
                        n_cnt = '0;
                        if (n_tag == TAG_DATA) begin
                            fmt_ok = (r_fmt == 16'd1) && (n_len != 32'd0) &&
                                     (r_width != 16'd0) && (r_ch != 16'd0);
                            wid_ok = (r_width == 16'd16) || (r_width == 16'd24) ||
                                     (r_width == 16'd32);
                            if (!fmt_ok || !wid_ok) begin
                                tmp = '0; tmp.kind = KIND_ERROR;
                                tmp.error_code = fmt_ok ? ERR_WIDTH : ERR_FORMAT;
                                r0v = 1'b1; r0 = tmp;
                                n_phase = PH_HALT;
                            end else begin
                                div_req.start = 1'b1;
                                n_phase = PH_DIV;
                            end
                        end else if (n_tag == TAG_FMT && n_len == 32'd0) begin
                            tmp = '0; tmp.kind = KIND_ERROR; tmp.error_code = ERR_FORMAT;
                            r0v = 1'b1; r0 = tmp;
                            n_phase = PH_HALT;
                        end else if (n_len == 32'd0) begin
                            n_phase = PH_HDR;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (r_tag == TAG_FMT && r_cnt < 32'd16) begin
                        if (r_cnt < 32'd2) n_fmt[r_cnt[0]*8 +: 8] = b;
                        else if (r_cnt < 32'd4) n_ch[r_cnt[0]*8 +: 8] = b;
                        else if (r_cnt < 32'd8) n_rate[r_cnt[1:0]*8 +: 8] = b;
                        else if (r_cnt >= 32'd14) n_width[r_cnt[0]*8 +: 8] = b;
                    end
                    n_cnt = r_cnt + 32'd1;
                    if (n_cnt >= r_len) begin
                        n_cnt   = '0;
                        n_phase = r_len[0] ? PH_PAD : PH_HDR;
                    end
                end
                PH_PAD: n_phase = PH_HDR;
                PH_DATA: begin
                    n_left = r_left - 32'd1;
                    if (r_emit != 32'd0) begin
                        n_emit = r_emit - 32'd1;
                        a32 = r_asm | (32'(b) << {r_bis, 3'b000});
                        if (({1'b0, r_bis} + 3'd1) == nb) begin
                            case (nb)
                                3'd2:    smp = {a32[15:0], 16'h0000};
                                3'd3:    smp = {a32[23:0], 8'h00};
                                default: smp = a32;
                            endcase
                            tmp = '0;
                            tmp.kind          = KIND_SAMPLE;
                            tmp.sample_q31    = $signed(smp);
                            tmp.channel_index = r_chan;
                            r0v = 1'b1; r0 = tmp;
                            chn    = {1'b0, r_chan} + 17'd1;
                            n_chan = (chn >= {1'b0, r_ch}) ? 16'd0 : chn[15:0];
                            n_asm  = '0;
                            n_bis  = '0;
                        end else begin
                            n_asm = a32;
                            n_bis = r_bis + 2'd1;
                        end
                    end
                    if (n_left == 32'd0) begin
                        tmp = '0; tmp.kind = KIND_OK;
                        if (!r0v) begin r0v = 1'b1; r0 = tmp; end
                        else begin r1v = 1'b1; r1 = tmp; end
                        n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase

            if (i_data.end_of_file) begin
                if (n_phase == PH_DIV) begin
                    n_eofp = 1'b1;
                end else begin
                    if (n_phase != PH_DONE && n_phase != PH_HALT) begin
                        tmp = '0; tmp.kind = KIND_ERROR;
                        tmp.error_code = (n_phase == PH_DATA) ? ERR_DAT_TRUNC
                                                              : ERR_HDR_TRUNC;
                        if (!r0v) begin r0v = 1'b1; r0 = tmp; end
                        else begin r1v = 1'b1; r1 = tmp; end
                    end
                    n_phase = PH_TOP; n_cnt = '0; n_tag = '0; n_len = '0;
                    n_fmt = '0; n_ch = '0; n_rate = '0; n_width = '0;
                    n_left = '0; n_emit = '0; n_asm = '0; n_bis = '0;
                    n_chan = '0; n_eofp = 1'b0;
                end
            end
        end

        if (r0v) begin
            o_push = 1'b1;
            o_res  = r0;
        end
        if (r1v) begin
            n_pend_v = 1'b1;
            n_pend   = r1;
        end
        div_req.dividend = n_len;
        div_req.divisor  = {15'd0, nb} * {2'd0, r_ch};
    end
endmodule

// ===== src/wrp_queue.sv =====
// Result queue between the parser and the output channel; head is the output.
// Depends on wrp_pkg.
module wrp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wrp_pkg::t_out i_res,
    output logic [2:0]    o_free,
    output logic          o_valid,
    output wrp_pkg::t_out o_data,
    input  logic          i_stall
);
    import wrp_pkg::*;

    t_out       r_mem [QDEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;
    logic       pop;

    assign o_valid = r_count != 3'd0;
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_free  = 3'(QDEPTH) - r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 2'd1;
            if (pop) r_rd <= r_rd + 2'd1;
            r_count <= r_count + {2'b00, i_push} - {2'b00, pop};
        end
        if (i_push) r_mem[r_wr] <= i_res;
    end
endmodule

// ===== src/wav_riff_pcm_parser_core.sv =====
// WAV RIFF/PCM parser core: top level joining the parser front and result queue.
// Depends on wrp_pkg, wrp_front, wrp_queue.
//
// Input channel: one file byte per beat (i_data.in_byte) with end_of_file on
// the last byte. Output channel: result beats of kind sample, format accepted,
// finished ok or error. Both use valid/stall; a beat moves when valid is high
// and stall is low.
// A result is registered in the result queue before it is offered on the output.
// Throughput: one byte per cycle while the input is not stalled. A byte that yields
// two results stalls the input while the second result is pushed. The data chunk
// header stalls the input while the serial divider works out the frame count.
// The four-entry result queue takes results while the receiver stalls; once
// it has fewer than two free entries the input is stalled.
// Reset clears the parser to expect a RIFF tag and empties the queue. After
// the end_of_file byte the core is back in that state for the next file.
module wav_riff_pcm_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wrp_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output wrp_pkg::t_out o_data,
    input  logic          i_stall
);
    import wrp_pkg::*;

    logic       push;
    t_out       res;
    logic [2:0] free;

    wrp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .i_free(free), .o_push(push), .o_res(res)
    );

    wrp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_res(res),
        .o_free(free), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );
endmodule

// ===== src/wrp_checker.sv =====
// Port-level checker for the WAV parser core, bound to the top level.
// Depends on wrp_pkg and wav_riff_pcm_parser_core_assert.svh.
`include "wav_riff_pcm_parser_core_assert.svh"
module wrp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input wrp_pkg::t_in  i_data,
    input logic          o_stall,
    input logic          o_valid,
    input wrp_pkg::t_out o_data,
    input logic          i_stall
);
    import wrp_pkg::*;

    `WRP_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_data), "beat changed")
    `WRP_ASSERT_NEXT_RAW(a_rst, !i_rst_n, !o_valid, "valid after reset")
    `WRP_ASSERT_IMPL(a_fmt, o_valid && o_data.kind == KIND_FORMAT, o_data.bits_per_sample == 6'd16 || o_data.bits_per_sample == 6'd24 || o_data.bits_per_sample == 6'd32, "bad width")
    `WRP_ASSERT_IMPL(a_err, o_valid && o_data.kind == KIND_ERROR, o_data.error_code != 3'd0 && o_data.sample_q31 == 32'sd0, "bad error beat")
    `WRP_ASSERT_IMPL(a_smp, o_valid && o_data.kind == KIND_SAMPLE, o_data.channel_count == 16'd0 && o_data.frame_total == 31'd0, "bad sample beat")
endmodule

bind wav_riff_pcm_parser_core wrp_checker u_chk (.*);

// ===== verif/wav_riff_pcm_parser_checker.sv =====
// Checker for the WAV parser core: watches both channels, predicts results
// from the accepted byte beats and compares them. Depends on wrp_pkg.
module wav_riff_pcm_parser_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wrp_pkg::t_in  i_data,
    input  logic          i_in_stall,
    input  logic          i_out_valid,
    input  wrp_pkg::t_out i_out_data,
    input  logic          i_out_stall,
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wrp_pkg::*;

    t_phase      phase;
    logic [31:0] byte_cnt, tag, clen, fcode, chans, rate, width;
    logic [31:0] bytes_left, smp_left, assembly, byte_pos, chan;
    t_out        results_due[$];
    int          mismatches;
    int          due_count;

    assign o_errors  = mismatches;
    assign o_pending = due_count;

    function automatic t_out blank_result();
        t_out r;
        r = '0;
        return r;
    endfunction

    task automatic clear_parser();
        phase = PH_TOP;
        {byte_cnt, tag, clen, fcode, chans, rate, width} = '0;
        {bytes_left, smp_left, assembly, byte_pos, chan} = '0;
    endtask

    task automatic push_error(logic [2:0] code);
        t_out r;
        r = blank_result();
        r.kind = KIND_ERROR;
        r.error_code = code;
        results_due.push_back(r);
        phase = PH_HALT;
    endtask

    function automatic logic [31:0] put_byte(logic [31:0] v, logic [7:0] b, int pos);
        logic [31:0] res;
        res = v;
        res[pos*8 +: 8] = b;
        return res;
    endfunction

    task automatic open_data();
        t_out        r;
        logic [31:0] frames;
        if (fcode != 1 || clen == 0 || width == 0 || chans == 0) begin
            push_error(ERR_FORMAT);
            return;
        end
        if (width != 16 && width != 24 && width != 32) begin
            push_error(ERR_WIDTH);
            return;
        end
        frames = clen / (width / 8) / chans;
        smp_left = frames * chans;
        bytes_left = clen;
        assembly = 0;
        byte_pos = 0;
        chan = 0;
        r = blank_result();
        r.kind = KIND_FORMAT;
        r.channel_count = chans[15:0];
        r.sample_rate_hz = rate;
        r.bits_per_sample = width[5:0];
        r.frame_total = frames[30:0];
        results_due.push_back(r);
        phase = PH_DATA;
    endtask

    task automatic predict_byte(t_in beat);
        logic [31:0] b, nb;
        t_out        r;
        b = {24'd0, beat.in_byte};
        case (phase)
            PH_TOP: begin
                tag = {b[7:0], tag[31:8]};
                if ((byte_cnt == 3 && tag != TAG_RIFF) ||
                    (byte_cnt == 11 && tag != TAG_WAVE)) begin
                    push_error(ERR_TAGS);
                end else begin
                    byte_cnt++;
                    if (byte_cnt >= 12) begin
                        byte_cnt = 0;
                        phase = PH_HDR;
                    end
                end
            end
            PH_HDR: begin
                if (byte_cnt < 4) tag = {b[7:0], tag[31:8]};
                else clen = {b[7:0], clen[31:8]};
                byte_cnt++;
                if (byte_cnt >= 8) begin
                    byte_cnt = 0;
                    if (tag == TAG_DATA) open_data();
                    else if (tag == TAG_FMT && clen == 0) push_error(ERR_FORMAT);
                    else if (clen == 0) phase = PH_HDR;
                    else phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (tag == TAG_FMT && byte_cnt < 16) begin
                    if (byte_cnt < 2) fcode = put_byte(fcode, b, byte_cnt);
                    else if (byte_cnt < 4) chans = put_byte(chans, b, byte_cnt - 2);
                    else if (byte_cnt < 8) rate = put_byte(rate, b, byte_cnt - 4);
                    else if (byte_cnt >= 14) width = put_byte(width, b, byte_cnt - 14);
                end
                byte_cnt++;
                if (byte_cnt >= clen) begin
                    byte_cnt = 0;
                    phase = clen[0] ? PH_PAD : PH_HDR;
                end
            end
            PH_PAD: phase = PH_HDR;
            PH_DATA: begin
                nb = width / 8;
                bytes_left--;
                if (smp_left != 0) begin
                    assembly = assembly | (b << (byte_pos[1:0] * 8));
                    if (byte_pos + 1 >= nb) begin
                        r = blank_result();
                        r.kind = KIND_SAMPLE;
                        r.sample_q31 = assembly << ((4 - nb) * 8);
                        r.channel_index = chan[15:0];
                        results_due.push_back(r);
                        chan++;
                        if (chan >= chans) chan = 0;
                        smp_left--;
                        assembly = 0;
                        byte_pos = 0;
                    end else begin
                        byte_pos++;
                    end
                end
                if (bytes_left == 0) begin
                    r = blank_result();
                    r.kind = KIND_OK;
                    results_due.push_back(r);
                    phase = PH_DONE;
                end
            end
            default: ;
        endcase
        if (beat.end_of_file) begin
            if (phase != PH_DONE && phase != PH_HALT)
                push_error(phase == PH_DATA ? ERR_DAT_TRUNC : ERR_HDR_TRUNC);
            clear_parser();
        end
    endtask

    task automatic compare_result(t_out got);
        t_out want;
        if (results_due.size() == 0) begin
            $error("result beat with nothing expected: kind %0d", got.kind);
            mismatches++;
            return;
        end
        want = results_due.pop_front();
        if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind); mismatches++;
        end
        if (got.sample_q31 != want.sample_q31) begin
            $error("sample_q31: expected %h, got %h", want.sample_q31, got.sample_q31);
            mismatches++;
        end
        if (got.channel_index != want.channel_index) begin
            $error("channel_index: expected %0d, got %0d", want.channel_index,
                   got.channel_index);
            mismatches++;
        end
        if (got.channel_count != want.channel_count) begin
            $error("channel_count: expected %0d, got %0d", want.channel_count,
                   got.channel_count);
            mismatches++;
        end
        if (got.sample_rate_hz != want.sample_rate_hz) begin
            $error("sample_rate_hz: expected %0d, got %0d", want.sample_rate_hz,
                   got.sample_rate_hz);
            mismatches++;
        end
        if (got.bits_per_sample != want.bits_per_sample) begin
            $error("bits_per_sample: expected %0d, got %0d", want.bits_per_sample,
                   got.bits_per_sample);
            mismatches++;
        end
        if (got.frame_total != want.frame_total) begin
            $error("frame_total: expected %0d, got %0d", want.frame_total,
                   got.frame_total);
            mismatches++;
        end
        if (got.error_code != want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            mismatches++;
        end
    endtask

    initial begin
        mismatches = 0;
        due_count = 0;
        clear_parser();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) compare_result(i_out_data);
            if (i_valid && !i_in_stall) predict_byte(i_data);
        end
        due_count = results_due.size();
    end
endmodule

// ===== verif/tb_wav_riff_pcm_parser_core.sv =====
// Testbench top for the WAV parser core: builds WAV byte streams, directed
// and random, with random idling. Depends on wrp_pkg, the core and the checker module.
module tb_wav_riff_pcm_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import wrp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    t_in  i_data;
    t_out o_data;
    int   failures, pending, cycles, bytes_sent;
    bit   quiet;
    logic [7:0] file_bytes[$];

    wav_riff_pcm_parser_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    wav_riff_pcm_parser_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .i_in_stall(o_stall), .i_out_valid(o_valid), .i_out_data(o_data),
        .i_out_stall(i_stall), .o_errors(failures), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall bursts
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                i_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    task automatic add_word(logic [31:0] w, int nbytes);
        for (int k = 0; k < nbytes; k++) file_bytes.push_back(w[k*8 +: 8]);
    endtask

    task automatic add_header(logic [31:0] tag, logic [31:0] len);
        add_word(tag, 4);
        add_word(len, 4);
    endtask

    task automatic add_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] rate,
                           logic [15:0] bits, int len);
        logic [7:0] body[16];
        add_header(TAG_FMT, len);
        {body[1], body[0]} = code;
        {body[3], body[2]} = ch;
        {body[7], body[6], body[5], body[4]} = rate;
        for (int k = 8; k < 14; k++) body[k] = $urandom;
        {body[15], body[14]} = bits;
        for (int k = 0; k < len; k++) file_bytes.push_back(k < 16 ? body[k] : $urandom);
        if (len[0]) file_bytes.push_back($urandom);
    endtask

    task automatic add_data(int len, int present);
        add_header(TAG_DATA, len);
        for (int k = 0; k < present; k++) file_bytes.push_back($urandom);
    endtask

    task automatic add_riff();
        add_header(TAG_RIFF, $urandom);
        add_word(TAG_WAVE, 4);
    endtask

    task automatic send_file();
        int gap;
        for (int k = 0; k < file_bytes.size(); k++) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_valid <= 1'b0;
                gap = $urandom_range(1, 10);
                repeat (gap) @(negedge i_clk);
            end
            i_valid <= 1'b1;
            i_data.in_byte <= file_bytes[k];
            i_data.end_of_file <= (k == file_bytes.size() - 1);
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            @(negedge i_clk);
            bytes_sent++;
        end
        i_valid <= 1'b0;
        i_data.end_of_file <= 1'b0;
        file_bytes.delete();
    endtask

    function automatic logic [15:0] pick_bits();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 7));
            1: return 16'($urandom);
            2, 3, 4: return 16'd16;
            5, 6: return 16'd24;
            default: return 16'd32;
        endcase
    endfunction

    task automatic random_file();
        int sel, ch, bits, len, nb, ulen;
        sel = $urandom_range(0, 19);
        bits = pick_bits();
        ch = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4);
        nb = (bits >= 8) ? bits / 8 : 1;
        len = $urandom_range(1, 3 * nb * ((ch < 8) ? ch : 2) + 2);
        if (sel == 0) begin
            for (int k = 0; k < $urandom_range(1, 14); k++) file_bytes.push_back($urandom);
        end else begin
            add_riff();
            if (sel == 1) file_bytes[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0) begin
                ulen = $urandom_range(0, 5);
                add_header($urandom, ulen);
                for (int k = 0; k < ulen; k++) file_bytes.push_back($urandom);
                if (ulen[0]) file_bytes.push_back($urandom);
            end
            add_fmt(($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'd1, ch,
                    $urandom, bits, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                    : $urandom_range(16, 19));
            if (sel == 2) add_fmt(1, $urandom_range(1, 2), $urandom, 16, $urandom_range(1, 16));
            if (sel == 3) len = 0;
            add_data(len, (sel == 4) ? $urandom_range(0, len) : len);
            if (sel == 5) file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
            for (int k = 0; k < $urandom_range(0, 2); k++) file_bytes.push_back($urandom);
        end
        send_file();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        quiet = 1'b0;
        bytes_sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: extremes of the 16 and 32 bit widths, fmt overrides, zero lengths, tags
        add_riff(); add_fmt(1, 2, 32'hFFFF_FFFF, 16, 16);
        add_word(16'h8000, 2); file_bytes.delete(file_bytes.size() - 1);
        file_bytes.delete(file_bytes.size() - 1);
        add_header(TAG_DATA, 8); add_word(32'h7FFF_8000, 4); add_word(32'hFFFF_0000, 4);
        send_file();
        add_riff(); add_fmt(1, 1, 0, 24, 18); add_data(7, 7); send_file();
        add_riff(); add_fmt(1, 65535, 44100, 32, 16); add_data(4, 4); send_file();
        add_riff(); add_fmt(1, 1, 8000, 32, 16); add_header(TAG_DATA, 8);
        add_word(32'h8000_0000, 4); add_word(32'h7FFF_FFFF, 4); send_file();
        add_riff(); add_header(32'h1234_5678, 3); add_word(32'hAABBCC, 4);
        add_fmt(3, 1, 1, 8, 16); add_fmt(1, 1, 1, 16, 2); add_data(3, 3); send_file();
        add_riff(); add_fmt(1, 1, 1, 4, 16); add_data(2, 2); send_file();
        add_riff(); add_fmt(1, 1, 1, 0, 16); add_data(2, 2); send_file();
        add_riff(); add_fmt(1, 0, 1, 16, 16); add_data(2, 2); send_file();
        add_riff(); add_fmt(1, 1, 1, 16, 0); send_file();
        add_riff(); add_fmt(1, 1, 1, 16, 16); add_data(0, 1); send_file();
        add_riff(); add_fmt(1, 1, 1, 16, 16); add_data(6, 3); send_file();
        add_riff(); add_fmt(1, 1, 1, 16, 16); add_header(TAG_DATA, 4); send_file();
        add_word(TAG_WAVE, 4); send_file();
        add_riff(); file_bytes[10] = 8'h00; send_file();
        add_riff(); add_word(0, 3); send_file();
        // pause until all results are in
        while (pending != 0) @(negedge i_clk);
        while (bytes_sent < 1300) random_file();
        quiet = 1'b1;
        while (bytes_sent < 1650) random_file();
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/wrp_pkg.sv
src/wrp_div.sv
src/wrp_front.sv
src/wrp_queue.sv
src/wav_riff_pcm_parser_core.sv
src/wrp_checker.sv
verif/wav_riff_pcm_parser_checker.sv
verif/tb_wav_riff_pcm_parser_core.sv
